FILE: design/mhq_pkg.sv
// shared types for the four-ary min-heap queue
// opcodes, memory address selects and the controller/datapath command and status structs
// no dependencies
package mhq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } op_t;

    // read address sources
    typedef enum logic [2:0] {
        RD_ROOT   = 3'd0,
        RD_PARENT = 3'd1,
        RD_LAST   = 3'd2,
        RD_CHILD0 = 3'd3,
        RD_NEXT   = 3'd4
    } rd_sel_t;

    // write data sources, always written at the current position
    typedef enum logic [1:0] {
        WR_KEY    = 2'd0,
        WR_PARENT = 2'd1,
        WR_BEST   = 2'd2
    } wr_sel_t;

    typedef struct packed {
        logic    load_op;
        logic    set_empty;
        logic    set_rej;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    pos_new;
        logic    pos_up;
        logic    pos_best;
        logic    take_top;
        logic    take_last;
        logic    lane_start;
        logic    lane_step;
        logic    count_inc;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic up_stop;
        logic parent_root;
        logic leaf;
        logic more;
        logic down_stop;
        logic out_free;
    } status_t;

endpackage

FILE: design/four_ary_min_heap_queue.sv
// four-ary min-heap priority queue of 32-bit keys; depends on mhq_pkg, mhq_ctrl, mhq_dp
// a peek reads the root only; a push sifts up level by level and a pop sifts down level
// by level, examining up to four children per level; one operation in flight at a time
// a result waits in the output register while stalled; the next result holds the queue
// reset: asynchronous active low, queue empty and no result pending; memory is not cleared
module four_ary_min_heap_queue #(
    parameter int CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [31:0] key_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] key_out,
    output logic        was_empty,
    output logic        push_rejected,
    output logic [8:0]  occupancy
);
    import mhq_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t status;

    // sequencer: decodes the opcode and walks the sift loops level by level
    mhq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: heap memory, counters, child comparison, output transfer register
    mhq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .key_in        (key_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .key_out       (key_out),
        .was_empty     (was_empty),
        .push_rejected (push_rejected),
        .occupancy     (occupancy)
    );

endmodule

FILE: design/mhq_dp.sv
// datapath of the four-ary min-heap queue: heap memory, position and child
// counters, best-child tracking and the output register
// depends on mhq_pkg
module mhq_dp #(
    parameter int CAPACITY = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mhq_pkg::cmd_t   cmd,
    output mhq_pkg::status_t status,
    input  logic [31:0]     key_in,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [31:0]     key_out,
    output logic            was_empty,
    output logic            push_rejected,
    output logic [8:0]      occupancy
);
    import mhq_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = CW + 2;

    logic [31:0]   mem [CAPACITY];
    logic [31:0]   rdata_reg;
    logic [31:0]   key_reg;
    logic [31:0]   best_val_reg;
    logic [CW-1:0] best_pos_reg;
    logic [31:0]   res_key_reg;
    logic          res_empty_reg;
    logic          res_rej_reg;
    logic [31:0]   key_out_reg;
    logic          was_empty_reg;
    logic          push_rejected_reg;
    logic [8:0]    occupancy_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] ch_reg, ch_next;
    logic [1:0]    lane_reg, lane_next;
    logic          out_valid_reg, out_valid_next;

    logic [XW-1:0] c0_wide;
    logic [CW-1:0] parent_pos;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    // first child of the current position is 4p-2
    assign c0_wide    = {pos_reg, 2'b00} - XW'(2);
    assign parent_pos = ((pos_reg - CW'(2)) >> 2) + CW'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_ROOT:   rd_addr = '0;
            RD_PARENT: rd_addr = AW'((pos_reg - CW'(2)) >> 2);
            RD_LAST:   rd_addr = AW'(count_reg - CW'(1));
            RD_CHILD0: rd_addr = AW'(c0_wide - XW'(1));
            RD_NEXT:   rd_addr = AW'(ch_reg);
            default:   rd_addr = '0;
        endcase
    end

    assign wr_addr = AW'(pos_reg - CW'(1));

    always_comb
    begin
        case (cmd.wr_sel)
            WR_KEY:    wr_data = key_reg;
            WR_PARENT: wr_data = rdata_reg;
            WR_BEST:   wr_data = best_val_reg;
            default:   wr_data = key_reg;
        endcase
    end

    // heap storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.take_last)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end

        pos_next = pos_reg;
        if (cmd.pos_new)
        begin
            pos_next = count_reg + CW'(1);
        end
        else if (cmd.take_last)
        begin
            pos_next = CW'(1);
        end
        else if (cmd.pos_up)
        begin
            pos_next = parent_pos;
        end
        else if (cmd.pos_best)
        begin
            pos_next = best_pos_reg;
        end

        ch_next   = ch_reg;
        lane_next = lane_reg;
        if (cmd.lane_start)
        begin
            ch_next   = CW'(c0_wide);
            lane_next = 2'd0;
        end
        else if (cmd.rd_en && (cmd.rd_sel == RD_NEXT))
        begin
            ch_next   = ch_reg + CW'(1);
            lane_next = lane_reg + 2'd1;
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            ch_reg        <= '0;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            ch_reg        <= ch_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            key_reg       <= key_in;
            res_key_reg   <= '0;
            res_empty_reg <= 1'b0;
            res_rej_reg   <= 1'b0;
        end
        if (cmd.set_empty)
        begin
            res_empty_reg <= 1'b1;
        end
        if (cmd.set_rej)
        begin
            res_rej_reg <= 1'b1;
        end
        if (cmd.take_top)
        begin
            res_key_reg <= rdata_reg;
        end
        if (cmd.take_last)
        begin
            key_reg <= rdata_reg;
        end
        // leftmost child wins a tie
        if (cmd.lane_step && ((lane_reg == 2'd0) || (rdata_reg < best_val_reg)))
        begin
            best_val_reg <= rdata_reg;
            best_pos_reg <= ch_reg;
        end
        if (cmd.out_load)
        begin
            key_out_reg       <= res_key_reg;
            was_empty_reg     <= res_empty_reg;
            push_rejected_reg <= res_rej_reg;
            occupancy_reg     <= 9'(count_reg);
        end
    end

    assign status.empty       = (count_reg == '0);
    assign status.full        = (count_reg == CW'(CAPACITY));
    assign status.up_stop     = (rdata_reg <= key_reg);
    assign status.parent_root = (parent_pos == CW'(1));
    assign status.leaf        = (c0_wide > XW'(count_reg));
    assign status.more        = (lane_reg != 2'd3) && (ch_reg < count_reg);
    assign status.down_stop   = (best_val_reg >= key_reg);
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign key_out       = key_out_reg;
    assign was_empty     = was_empty_reg;
    assign push_rejected = push_rejected_reg;
    assign occupancy     = occupancy_reg;

endmodule

FILE: design/mhq_ctrl.sv
// controller of the four-ary min-heap queue: sequences sift-up and sift-down
// depends on mhq_pkg
module mhq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       opcode,
    input  mhq_pkg::status_t status,
    output mhq_pkg::cmd_t    cmd
);
    import mhq_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_UP_RD    = 10'b00_0000_0010,
        S_UP_CMP   = 10'b00_0000_0100,
        S_TOP_GET  = 10'b00_0000_1000,
        S_LAST_GET = 10'b00_0001_0000,
        S_DN_CHK   = 10'b00_0010_0000,
        S_DN_RD    = 10'b00_0100_0000,
        S_DN_CMP   = 10'b00_1000_0000,
        S_PLACE    = 10'b01_0000_0000,
        S_FINISH   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_op = 1'b1;
                    op_next     = op_t'(opcode);
                    case (op_t'(opcode))
                        OP_PUSH:
                        begin
                            if (status.full)
                            begin
                                cmd.set_rej = 1'b1;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                cmd.pos_new = 1'b1;
                                state_next  = status.empty ? S_PLACE : S_UP_RD;
                            end
                        end
                        OP_POP, OP_PEEK:
                        begin
                            if (status.empty)
                            begin
                                cmd.set_empty = 1'b1;
                                state_next    = S_FINISH;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = RD_ROOT;
                                state_next = S_TOP_GET;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PARENT;
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (status.up_stop)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    // parent moves down into the hole
                    cmd.wr_en  = 1'b1;
                    cmd.wr_sel = WR_PARENT;
                    cmd.pos_up = 1'b1;
                    state_next = status.parent_root ? S_PLACE : S_UP_RD;
                end
            end
            S_TOP_GET:
            begin
                cmd.take_top = 1'b1;
                if (op_reg == OP_PEEK)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LAST;
                    state_next = S_LAST_GET;
                end
            end
            S_LAST_GET:
            begin
                cmd.take_last = 1'b1;
                state_next    = S_DN_CHK;
            end
            S_DN_CHK:
            begin
                if (status.leaf)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.lane_start = 1'b1;
                    cmd.rd_en      = 1'b1;
                    cmd.rd_sel     = RD_CHILD0;
                    state_next     = S_DN_RD;
                end
            end
            S_DN_RD:
            begin
                cmd.lane_step = 1'b1;
                if (status.more)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (status.down_stop)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_sel   = WR_BEST;
                    cmd.pos_best = 1'b1;
                    state_next   = S_DN_CHK;
                end
            end
            S_PLACE:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = WR_KEY;
                cmd.count_inc = (op_reg == OP_PUSH);
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule
